### rtl/drt_pkg.sv
// shared types and codes for the disjoint range table
`default_nettype none
package drt_pkg;

    localparam int MAX_RANGES_DEF = 16;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_FIND  = 2'd1;
    localparam logic [1:0] FUNC_ERASE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] high;
        logic [31:0] low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic hit;
        logic free;
    } match_t;

endpackage
`default_nettype wire

### rtl/drt_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/drt_match.sv
// compares one stored entry against the current request
`default_nettype none
module drt_match (
    input  wire logic [1:0]     func,
    input  wire logic [31:0]    key_low,
    input  wire logic [31:0]    key_high,
    input  wire drt_pkg::entry_t entry,
    output drt_pkg::match_t     result
);

    always_comb
    begin
        result.free = !entry.valid;
        case (func)
            drt_pkg::FUNC_ADD:
                result.hit = entry.valid && (key_low <= entry.high) && (entry.low <= key_high);
            drt_pkg::FUNC_FIND:
                result.hit = entry.valid && (entry.low <= key_low) && (key_low <= entry.high);
            drt_pkg::FUNC_ERASE:
                result.hit = entry.valid && (entry.low == key_low);
            default:
                result.hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/disjoint_range_table_core.sv
// disjoint range table: request sequencer around the entry ram
//
// Requests come in on req_valid/req_stall with func, key_low and key_high;
// one result per request leaves on rsp_valid/rsp_stall with status,
// found_low and found_high. A transfer happens when valid is high and stall
// is low.
// Add, find and erase read every entry of the ram in turn, one per cycle,
// then decide and write back at most one entry; the next request is taken
// only once the result is loaded into the output register, so a request
// is never taken while the one before it is still in flight.
// An inverted add (key_low above key_high) is answered with a miss and
// skips the scan.
// Clear writes every entry invalid, one per cycle.
// After reset the same clearing pass runs over every entry, during
// which req_stall is high.
// The result sits in an output register; while rsp_stall is high it holds
// and a finished request waits before the sequencer goes idle again.
`default_nettype none
module disjoint_range_table_core #(
    parameter int MAX_RANGES = drt_pkg::MAX_RANGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] key_low,
    input  wire logic [31:0] key_high,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic [31:0]      found_low,
    output logic [31:0]      found_high
);

    localparam int IW = $clog2(MAX_RANGES > 1 ? MAX_RANGES : 2);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(MAX_RANGES);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_RANGES - 1);

    typedef enum logic [4:0] {
        ST_INIT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_CLR  = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0] hit_low_reg, hit_low_next, hit_high_reg, hit_high_next;
    logic free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [1:0] func_reg, func_next;
    logic [31:0] key_low_reg, key_low_next, key_high_reg, key_high_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [31:0] res_low_reg, res_low_next, res_high_reg, res_high_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [1:0] status_reg, status_next;
    logic [31:0] found_low_reg, found_low_next, found_high_reg, found_high_next;

    logic ram_we;
    logic [IW-1:0] ram_waddr;
    drt_pkg::entry_t ram_wdata, ram_rdata;
    logic [drt_pkg::ENTRY_W-1:0] ram_rdata_raw;
    drt_pkg::match_t match;

    drt_ram #(
        .WIDTH(drt_pkg::ENTRY_W),
        .DEPTH(MAX_RANGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = drt_pkg::entry_t'(ram_rdata_raw);

    drt_match u_match (
        .func     (func_reg),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .entry    (ram_rdata),
        .result   (match)
    );

    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign found_low  = found_low_reg;
    assign found_high = found_high_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = cnt_reg[IW-1:0];
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_low_next    = hit_low_reg;
        hit_high_next   = hit_high_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        func_next       = func_reg;
        key_low_next    = key_low_reg;
        key_high_next   = key_high_reg;
        res_status_next = res_status_reg;
        res_low_next    = res_low_reg;
        res_high_next   = res_high_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        status_next     = status_reg;
        found_low_next  = found_low_reg;
        found_high_next = found_high_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[IW-1:0];
        ram_wdata       = '0;

        unique case (state_reg) inside
            ST_INIT, ST_CLR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    res_status_next = drt_pkg::STATUS_OK;
                    res_low_next    = '0;
                    res_high_next   = '0;
                    state_next      = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next     = func;
                    key_low_next  = key_low;
                    key_high_next = key_high;
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    res_low_next  = '0;
                    res_high_next = '0;
                    if (func == drt_pkg::FUNC_CLEAR)
                    begin
                        state_next = ST_CLR;
                    end
                    else if (func == drt_pkg::FUNC_ADD && key_low > key_high)
                    begin
                        res_status_next = drt_pkg::STATUS_MISS;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    chk_vld_next = 1'b1;
                end
                if (chk_vld_reg)
                begin
                    // keep the lowest-numbered hit and free slot
                    if (match.hit && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_low_next  = ram_rdata.low;
                        hit_high_next = ram_rdata.high;
                    end
                    if (match.free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
                else if (cnt_reg == CNT_END)
                begin
                    state_next = ST_RESP;
                    case (func_reg)
                        drt_pkg::FUNC_FIND:
                        begin
                            if (hit_reg)
                            begin
                                res_status_next = drt_pkg::STATUS_OK;
                                res_low_next    = hit_low_reg;
                                res_high_next   = hit_high_reg;
                            end
                            else
                            begin
                                res_status_next = drt_pkg::STATUS_MISS;
                            end
                        end
                        drt_pkg::FUNC_ERASE:
                        begin
                            if (hit_reg)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = hit_idx_reg;
                                ram_wdata.valid = 1'b0;
                                ram_wdata.low   = hit_low_reg;
                                ram_wdata.high  = hit_high_reg;
                                res_status_next = drt_pkg::STATUS_OK;
                            end
                            else
                            begin
                                res_status_next = drt_pkg::STATUS_MISS;
                            end
                        end
                        default:
                        begin
                            if (hit_reg)
                            begin
                                res_status_next = drt_pkg::STATUS_MISS;
                            end
                            else if (!free_reg)
                            begin
                                res_status_next = drt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = free_idx_reg;
                                ram_wdata.valid = 1'b1;
                                ram_wdata.low   = key_low_reg;
                                ram_wdata.high  = key_high_reg;
                                res_status_next = drt_pkg::STATUS_OK;
                            end
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                // wait for the output register to drain
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    found_low_next  = res_low_reg;
                    found_high_next = res_high_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_low_reg    <= hit_low_next;
        hit_high_reg   <= hit_high_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        func_reg       <= func_next;
        key_low_reg    <= key_low_next;
        key_high_reg   <= key_high_next;
        res_status_reg <= res_status_next;
        res_low_reg    <= res_low_next;
        res_high_reg   <= res_high_next;
        status_reg     <= status_next;
        found_low_reg  <= found_low_next;
        found_high_reg <= found_high_next;
    end

endmodule
`default_nettype wire

### dv/disjoint_range_table_core_tb.sv
// testbench for disjoint_range_table_core: directed table, a fill sequence, then random request episodes
`default_nettype none
module disjoint_range_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = drt_pkg::MAX_RANGES_DEF;
    localparam int ITEM_TARGET    = 950;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lo;
        logic [31:0] hi;
    } range_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   lo;
        logic [31:0]   hi;
        logic          typed;
        range_result_t res;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam range_result_t NO_RESULT = '{drt_pkg::STATUS_OK, 32'h0, 32'h0};

    // rows with typed = 1 carry their own expected result
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{drt_pkg::FUNC_FIND,  32'h0, 32'h0, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ERASE, 32'h0, 32'h0, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'h1, 32'h0, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'hFFFFFFFF, 32'h0, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'h0, 32'h0, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_FIND,  32'h0, 32'h0, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_FIND,  32'hFFFFFFFF, 32'h0, 1'b1,
          '{drt_pkg::STATUS_OK, 32'hFFFFFFFF, 32'hFFFFFFFF}},
        '{drt_pkg::FUNC_ADD,   32'h0, 32'h5, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'h1,        32'hA,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ADD,   32'hA,        32'h14,       1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ADD,   32'h15,       32'hFFFFFFFE, 1'b0, NO_RESULT},
        '{drt_pkg::FUNC_FIND,  32'h5,        32'h0,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_FIND,  32'h80000000, 32'h0,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_FIND,  32'h55555555, 32'hAAAAAAAA, 1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ERASE, 32'h1,        32'h0,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ERASE, 32'h2,        32'hFFFFFFFF, 1'b0, NO_RESULT},
        '{drt_pkg::FUNC_FIND,  32'h5,        32'h0,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ERASE, 32'hFFFFFFFF, 32'h0,        1'b0, NO_RESULT},
        '{drt_pkg::FUNC_ADD,   32'h1,        32'hFFFFFFFF, 1'b0, NO_RESULT},
        '{drt_pkg::FUNC_CLEAR, 32'h0, 32'h0, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_FIND,  32'hFFFFFFFF, 32'h0, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'h0, 32'hFFFFFFFF, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_ADD,   32'h5A5A5A5A, 32'h5A5A5A5A, 1'b1,
          '{drt_pkg::STATUS_MISS, 32'h0, 32'h0}},
        '{drt_pkg::FUNC_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{drt_pkg::STATUS_OK, 32'h0, 32'h0}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  func = drt_pkg::FUNC_FIND;
    logic [31:0] key_low = 32'h0;
    logic [31:0] key_high = 32'h0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] found_low;
    logic [31:0] found_high;

    // shadow copy of the range table
    logic [31:0] shadow_low [TABLE_DEPTH];
    logic [31:0] shadow_high [TABLE_DEPTH];
    bit          shadow_used [TABLE_DEPTH];

    range_result_t pending_results [$];
    int          fail_count = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    disjoint_range_table_core #(
        .MAX_RANGES(TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .key_low   (key_low),
        .key_high  (key_high),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .found_low (found_low),
        .found_high(found_high)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    function automatic range_result_t range_table_apply(logic [1:0] op, logic [31:0] lo,
                                                        logic [31:0] hi);
        range_result_t r;
        int free_idx;
        bit overlap;
        bit done;
        r = NO_RESULT;
        free_idx = -1;
        overlap = 1'b0;
        done = 1'b0;
        case (op)
            drt_pkg::FUNC_ADD:
            begin
                if (lo > hi)
                    r.status = drt_pkg::STATUS_MISS;
                else
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (shadow_used[i])
                        begin
                            if (lo <= shadow_high[i] && shadow_low[i] <= hi)
                                overlap = 1'b1;
                        end
                        else if (free_idx < 0)
                            free_idx = i;
                    end
                    if (overlap)
                        r.status = drt_pkg::STATUS_MISS;
                    else if (free_idx < 0)
                        r.status = drt_pkg::STATUS_FULL;
                    else
                    begin
                        shadow_low[free_idx] = lo;
                        shadow_high[free_idx] = hi;
                        shadow_used[free_idx] = 1'b1;
                    end
                end
            end
            drt_pkg::FUNC_FIND:
            begin
                r.status = drt_pkg::STATUS_MISS;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!done && shadow_used[i] && shadow_low[i] <= lo && lo <= shadow_high[i])
                    begin
                        r = '{drt_pkg::STATUS_OK, shadow_low[i], shadow_high[i]};
                        done = 1'b1;
                    end
                end
            end
            drt_pkg::FUNC_ERASE:
            begin
                r.status = drt_pkg::STATUS_MISS;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!done && shadow_used[i] && shadow_low[i] == lo)
                    begin
                        shadow_used[i] = 1'b0;
                        r.status = drt_pkg::STATUS_OK;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    shadow_used[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_stored_slot();
        int n;
        int pick;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_used[i])
                n++;
        if (n == 0)
            return -1;
        pick = $urandom_range(0, n - 1);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (shadow_used[i])
            begin
                if (pick == 0)
                    return i;
                pick--;
            end
        end
        return -1;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFFFFFF : sum[31:0];
    endfunction

    function automatic logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
        return (b > a) ? 32'h0 : a - b;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] lo,
                                input logic [31:0] hi, input bit use_typed,
                                input range_result_t typed_res);
        int gap;
        range_result_t predicted;
        range_result_t expected;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= op;
        key_low <= lo;
        key_high <= hi;
        do
            @(posedge clk);
        while (req_stall);
        predicted = range_table_apply(op, lo, hi);
        expected = use_typed ? typed_res : predicted;
        pending_results = {pending_results, expected};
        items_sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_add();
        logic [31:0] lo;
        logic [31:0] hi;
        int kind;
        int s;
        kind = $urandom_range(0, 9);
        s = pick_stored_slot();
        if (s < 0 && kind >= 5 && kind <= 7)
            kind = 0;
        lo = $urandom;
        case (kind)
            5:
            begin
                // shares the stored high end point
                lo = shadow_high[s];
                hi = sat_add(lo, $urandom_range(0, 255));
            end
            6:
            begin
                // butts against a stored range without touching it
                if ($urandom_range(0, 1) && shadow_low[s] != 32'h0)
                begin
                    hi = shadow_low[s] - 32'h1;
                    lo = sat_sub(hi, $urandom_range(0, 255));
                end
                else
                begin
                    lo = sat_add(shadow_high[s], 32'h1);
                    hi = sat_add(lo, $urandom_range(0, 255));
                end
            end
            7:
            begin
                lo = sat_sub(shadow_low[s], $urandom_range(0, 15));
                hi = sat_add(shadow_high[s], $urandom_range(0, 15));
            end
            8:
            begin
                if (lo == 32'h0)
                    lo = 32'h1;
                hi = $urandom_range(0, lo - 32'h1);
            end
            9:
                hi = $urandom;
            default:
                hi = $urandom_range(0, 3) == 0 ? sat_add(lo, $urandom)
                                               : sat_add(lo, $urandom_range(0, 4095));
        endcase
        send_request(drt_pkg::FUNC_ADD, lo, hi, 1'b0, NO_RESULT);
    endtask

    task automatic send_random_find();
        logic [31:0] pt;
        logic [31:0] span;
        int s;
        s = pick_stored_slot();
        pt = $urandom;
        if (s >= 0 && $urandom_range(0, 9) < 7)
        begin
            span = shadow_high[s] - shadow_low[s];
            case ($urandom_range(0, 3))
                0: pt = shadow_low[s];
                1: pt = shadow_high[s];
                2: pt = sat_add(shadow_high[s], 32'h1);
                default: pt = shadow_low[s] +
                              ((span == 32'hFFFFFFFF) ? $urandom : $urandom % (span + 32'h1));
            endcase
        end
        send_request(drt_pkg::FUNC_FIND, pt, $urandom, 1'b0, NO_RESULT);
    endtask

    task automatic send_random_erase();
        logic [31:0] lo;
        int s;
        int pick;
        s = pick_stored_slot();
        pick = $urandom_range(0, 99);
        lo = $urandom;
        if (s >= 0 && pick < 65)
            lo = shadow_low[s];
        else if (s >= 0 && pick < 80)
            lo = sat_add(shadow_low[s], 32'h1);
        send_request(drt_pkg::FUNC_ERASE, lo, $urandom, 1'b0, NO_RESULT);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_random_add();
        else if (pick < 80)
            send_random_find();
        else if (pick < 97)
            send_random_erase();
        else
            send_request(drt_pkg::FUNC_CLEAR, $urandom, $urandom, 1'b0, NO_RESULT);
    endtask

    // clear and fill every slot with disjoint ranges, then hit the full table, erase one and add again
    task automatic run_fill_sequence();
        logic [31:0] lo;
        int s;
        send_request(drt_pkg::FUNC_CLEAR, $urandom, $urandom, 1'b0, NO_RESULT);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            lo = (i << 28) + $urandom_range(0, 32'h07FFFFFF);
            send_request(drt_pkg::FUNC_ADD, lo, lo + $urandom_range(0, 32'h07FFFFFF), 1'b0,
                         NO_RESULT);
        end
        send_request(drt_pkg::FUNC_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_RESULT);
        send_request(drt_pkg::FUNC_ADD, 32'h0, 32'h0FFFFFFF, 1'b0, NO_RESULT);
        for (int i = 0; i < 4; i++)
            send_random_find();
        s = pick_stored_slot();
        send_request(drt_pkg::FUNC_ERASE, shadow_low[s], 32'h0, 1'b0, NO_RESULT);
        send_request(drt_pkg::FUNC_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_RESULT);
        send_request(drt_pkg::FUNC_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_RESULT);
    endtask

    // result checker
    always @(posedge clk)
    begin
        range_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d", status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (found_low !== want.lo)
                begin
                    $error("found_low: expected %h, got %h", want.lo, found_low);
                    fail_count++;
                end
                if (found_high !== want.hi)
                begin
                    $error("found_high: expected %h, got %h", want.hi, found_high);
                    fail_count++;
                end
            end
        end
    end

    // result side stall
    initial
    begin
        int hold;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].op, DIRECTED[i].lo, DIRECTED[i].hi, DIRECTED[i].typed,
                         DIRECTED[i].res);

        run_fill_sequence();
        // hold the sender off until the table has answered everything
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            len = $urandom_range(10, 80);
            send_request(drt_pkg::FUNC_CLEAR, $urandom, $urandom, 1'b0, NO_RESULT);
            for (int j = 0; j < len && items_sent < ITEM_TARGET; j++)
                send_random_request();
        end
        no_idle = 1'b0;

        drain_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/drt_pkg.sv
rtl/drt_ram.sv
rtl/drt_match.sv
rtl/disjoint_range_table_core.sv
dv/disjoint_range_table_core_tb.sv
